FILE: design/lrukfr_pkg.sv
// shared types and codes of the lru-k frame replacer
package lrukfr_pkg;

  localparam int KIND_W   = 2;
  localparam int FRAME_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int HK_W     = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // tracked frames never exceed what the frame field can address
  localparam int FRAME_SPAN = 1 << FRAME_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EVICT  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_PINNED = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // register index, taken from paddr[2]
  localparam logic REG_HISTORY_K     = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

endpackage

FILE: design/lrukfr_if.sv
// request and response channel interfaces of the lru-k frame replacer
interface lrukfr_req_if;
  logic                       valid;
  logic                       ready;
  lrukfr_pkg::kind_t          kind;
  logic [lrukfr_pkg::FRAME_W-1:0] frame;
  logic                       evictable;

  modport source (output valid, output kind, output frame, output evictable, input ready);
  modport sink   (input valid, input kind, input frame, input evictable, output ready);
endinterface

interface lrukfr_rsp_if;
  logic                           valid;
  logic                           ready;
  lrukfr_pkg::status_t            status;
  logic [lrukfr_pkg::FRAME_W-1:0] victim;
  logic [lrukfr_pkg::COUNT_W-1:0] evictable_count;

  modport source (output valid, output status, output victim, output evictable_count,
                  input ready);
  modport sink   (input valid, input status, input victim, input evictable_count,
                  output ready);
endinterface

FILE: design/lru_k_frame_replacer.sv
// lru-k frame replacer: request decode, victim scan and per-frame history state
//
// One request beat is taken at a time. Access, mark and remove requests go
// from idle straight to the execute state, which loads their response beat
// into the output register once that register is free; the next request beat
// is taken only after that. An evict walks every trackable frame through a
// three-stage scan: a per-frame metadata memory read, an access-history memory
// read, and one shared compare against the best candidate so far, one frame
// per cycle. It then passes through a drain state, the execute state and idle
// before the next request beat is taken. The request channel is not ready
// while a request is in progress; the response sits in an output register, so
// a waiting response beat does not hold off the next request until that
// request has finished. Tracked and pinned flags live in flip-flops cleared by
// reset, so no clearing pass is run; history times are only read after they
// were written. Only frames below 64 can ever be addressed, so FRAME_COUNT
// above 64 adds no storage. History_k of zero behaves as one and values above
// HISTORY_DEPTH as HISTORY_DEPTH.
module lru_k_frame_replacer #(
  parameter int FRAME_COUNT   = 64,
  parameter int HISTORY_DEPTH = 8,
  parameter int TIME_BITS     = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  lrukfr_req_if.sink           req,
  lrukfr_rsp_if.source         rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [lrukfr_pkg::APB_AW-1:0] paddr,
  input  logic [lrukfr_pkg::APB_DW-1:0] pwdata,
  output logic [lrukfr_pkg::APB_DW-1:0] prdata,
  output logic                 pready
);
  import lrukfr_pkg::*;

  // frames that can ever be tracked
  localparam int TRACK = (FRAME_COUNT < FRAME_SPAN) ? FRAME_COUNT : FRAME_SPAN;
  localparam int IW    = $clog2(TRACK);
  localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int HDEPTH = TRACK * HISTORY_DEPTH;
  localparam int AW    = $clog2(HDEPTH);
  localparam int RW    = HW + 2;  // ring arithmetic, holds up to 2*HISTORY_DEPTH-1

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } meta_t;

  // control and configuration
  state_t               state;
  logic [HK_W-1:0]      history_k;
  logic [COUNT_W-1:0]   frames_in_use;
  logic [TRACK-1:0]     tracked;
  logic [TRACK-1:0]     pinned;
  logic [COUNT_W-1:0]   evictable_total;
  logic [TIME_BITS-1:0] time_now;

  // latched request
  kind_t                req_kind;
  logic [FRAME_W-1:0]   req_frame;
  logic                 req_mark;

  // scan sequencer and best candidate
  logic [IW-1:0]        scan_idx;
  logic                 drain_cnt;
  logic                 found;
  logic [IW-1:0]        best_idx;
  logic                 best_few;
  logic [TIME_BITS-1:0] best_t;

  // response register
  logic                 out_valid;
  status_t              out_status;
  logic [FRAME_W-1:0]   out_victim;
  logic [COUNT_W-1:0]   out_count;

  // memories
  meta_t                meta_mem [TRACK];
  meta_t                meta_rd;
  logic [IW-1:0]        meta_raddr;
  logic [TIME_BITS-1:0] hist_mem [HDEPTH];
  logic [TIME_BITS-1:0] hist_rd;
  logic [AW-1:0]        hist_raddr;
  logic [AW-1:0]        hist_waddr;
  logic                 hist_we;

  // scan pipeline
  logic                 s1_valid;
  logic [IW-1:0]        s1_idx;
  logic                 s1_few;
  logic [CW-1:0]        s1_used;
  logic [RW-1:0]        ring_sum;
  logic [HW-1:0]        s1_slot;
  logic                 s2_valid;
  logic [IW-1:0]        s2_idx;
  logic                 s2_few;
  logic                 s2_take;

  // execute decode
  logic [CW-1:0]        eff_k;
  logic                 cfg_write;
  logic                 out_free;
  logic                 commit;
  logic [IW-1:0]        req_idx;
  logic                 in_range;
  logic                 cur_trk;
  logic                 cur_pin;
  logic [HW-1:0]        cur_head;
  logic [CW-1:0]        cur_count;
  logic [HW-1:0]        head_inc;
  logic [CW-1:0]        count_inc;
  logic [TIME_BITS-1:0] time_inc;
  logic                 time_step;
  status_t              st_next;
  logic [FRAME_W-1:0]   vic_next;
  logic [COUNT_W-1:0]   ev_next;
  logic                 upd_en;
  logic [IW-1:0]        upd_idx;
  logic                 upd_trk;
  logic                 upd_pin;

  // apb side: always ready, register chosen by paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_HISTORY_K:     prdata = APB_DW'(history_k);
      REG_FRAMES_IN_USE: prdata = APB_DW'(frames_in_use);
      default:           prdata = '0;
    endcase
  end

  // effective k, clamped to 1..HISTORY_DEPTH
  always_comb begin
    if (history_k == '0) begin
      eff_k = CW'(1);
    end else if (32'(history_k) > HISTORY_DEPTH) begin
      eff_k = CW'(HISTORY_DEPTH);
    end else begin
      eff_k = CW'(history_k);
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.victim          = out_victim;
  assign rsp.evictable_count = out_count;

  assign out_free = !out_valid || rsp.ready;
  assign commit   = (state == S_EXEC) && out_free;

  // per-frame metadata memory, one registered read a cycle
  always_comb begin
    case (state)
      S_IDLE:  meta_raddr = req.frame[IW-1:0];
      S_SCAN:  meta_raddr = scan_idx;
      default: meta_raddr = req_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    meta_rd <= meta_mem[meta_raddr];
    if (hist_we) begin
      meta_mem[req_idx] <= '{head: head_inc, count: count_inc};
    end
  end

  // access-history memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    hist_rd <= hist_mem[hist_raddr];
    if (hist_we) begin
      hist_mem[hist_waddr] <= time_inc;
    end
  end

  // scan stage 1: metadata is back, find the front of the k window
  assign s1_few   = meta_rd.count < eff_k;
  assign s1_used  = s1_few ? meta_rd.count : eff_k;
  assign ring_sum = RW'(meta_rd.head) + RW'(HISTORY_DEPTH) - RW'(s1_used);
  assign s1_slot  = (ring_sum >= RW'(HISTORY_DEPTH)) ? HW'(ring_sum - RW'(HISTORY_DEPTH))
                                                      : HW'(ring_sum);
  assign hist_raddr = AW'(32'(s1_idx) * HISTORY_DEPTH + 32'(s1_slot));

  // scan stage 2: the one shared compare; fewer-than-k wins, then older front,
  // ties keep the lower index
  always_comb begin
    if (!found) begin
      s2_take = s2_valid;
    end else if (s2_few != best_few) begin
      s2_take = s2_valid && s2_few;
    end else begin
      s2_take = s2_valid && (hist_rd < best_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_SCAN) && tracked[scan_idx] && !pinned[scan_idx];
      s2_valid <= s1_valid;
    end
    s1_idx <= scan_idx;
    s2_idx <= s1_idx;
    s2_few <= s1_few;
  end

  // execute decode for the latched request
  assign req_idx   = req_frame[IW-1:0];
  assign in_range  = ({1'b0, req_frame} < frames_in_use) && (32'(req_frame) < FRAME_COUNT);
  assign cur_trk   = tracked[req_idx];
  assign cur_pin   = pinned[req_idx];
  assign cur_head  = cur_trk ? meta_rd.head : '0;
  assign cur_count = cur_trk ? meta_rd.count : '0;
  assign head_inc  = (32'(cur_head) == HISTORY_DEPTH - 1) ? '0 : cur_head + HW'(1);
  assign count_inc = (32'(cur_count) < HISTORY_DEPTH) ? cur_count + CW'(1) : cur_count;
  // time saturates at all ones
  assign time_inc  = (time_now != '1) ? time_now + TIME_BITS'(1) : time_now;
  assign hist_waddr = AW'(32'(req_idx) * HISTORY_DEPTH + 32'(cur_head));
  assign hist_we   = commit && (req_kind == KIND_ACCESS) && in_range;

  always_comb begin
    st_next   = ST_OK;
    vic_next  = '0;
    ev_next   = evictable_total;
    upd_en    = 1'b0;
    upd_idx   = req_idx;
    upd_trk   = 1'b0;
    upd_pin   = 1'b0;
    time_step = 1'b0;
    if (req_kind == KIND_EVICT) begin
      if (found) begin
        vic_next = FRAME_W'(best_idx);
        upd_en   = 1'b1;
        upd_idx  = best_idx;
        if (evictable_total != '0) begin
          ev_next = evictable_total - COUNT_W'(1);
        end
      end else begin
        st_next = ST_EMPTY;
      end
    end else if (!in_range) begin
      st_next = ST_RANGE;
    end else begin
      case (req_kind)
        KIND_ACCESS: begin
          time_step = 1'b1;
          // first access starts tracking, unpinned
          if (!cur_trk) begin
            upd_en  = 1'b1;
            upd_trk = 1'b1;
            ev_next = evictable_total + COUNT_W'(1);
          end
        end
        KIND_MARK: begin
          if (cur_trk && req_mark && cur_pin) begin
            upd_en  = 1'b1;
            upd_trk = 1'b1;
            ev_next = evictable_total + COUNT_W'(1);
          end else if (cur_trk && !req_mark && !cur_pin) begin
            upd_en  = 1'b1;
            upd_trk = 1'b1;
            upd_pin = 1'b1;
            if (evictable_total != '0) begin
              ev_next = evictable_total - COUNT_W'(1);
            end
          end
        end
        KIND_REMOVE: begin
          if (cur_trk && cur_pin) begin
            st_next = ST_PINNED;
          end else if (cur_trk) begin
            upd_en = 1'b1;
            if (evictable_total != '0) begin
              ev_next = evictable_total - COUNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, frame flags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      history_k       <= HK_W'(2);
      frames_in_use   <= COUNT_W'(64);
      tracked         <= '0;
      pinned          <= '0;
      evictable_total <= '0;
      time_now        <= '0;
      found           <= 1'b0;
      drain_cnt       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // a commit in the same cycle reloads the response register instead
      if (out_valid && rsp.ready && !commit) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (paddr[2])
          REG_HISTORY_K:     history_k     <= pwdata[HK_W-1:0];
          REG_FRAMES_IN_USE: frames_in_use <= pwdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_kind  <= req.kind;
            req_frame <= req.frame;
            req_mark  <= req.evictable;
            found     <= 1'b0;
            scan_idx  <= '0;
            state     <= (req.kind == KIND_EVICT) ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (32'(scan_idx) == TRACK - 1) begin
            drain_cnt <= 1'b0;
            state     <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_DRAIN: begin
          // the drain lets the last frame pass both memory reads and reach the compare
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= st_next;
            out_victim      <= vic_next;
            out_count       <= ev_next;
            evictable_total <= ev_next;
            if (upd_en) begin
              tracked[upd_idx] <= upd_trk;
              pinned[upd_idx]  <= upd_pin;
            end
            if (time_step) begin
              time_now <= time_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (s2_take) begin
        found    <= 1'b1;
        best_idx <= s2_idx;
        best_few <= s2_few;
        best_t   <= hist_rd;
      end
    end
  end

  // evictable total tracks the tracked, unpinned frames
  a_ev_total: assert property (@(posedge clk) disable iff (rst)
    32'(evictable_total) == $countones(tracked & ~pinned))
    else $error("evictable total out of step with frame flags");

  a_pin_tracked: assert property (@(posedge clk) disable iff (rst)
    (pinned & ~tracked) == '0)
    else $error("untracked frame marked pinned");

  a_victim_cleared: assert property (@(posedge clk) disable iff (rst)
    (commit && req_kind == KIND_EVICT && found) |=> !tracked[$past(best_idx)])
    else $error("victim still tracked after evict");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> rsp.evictable_count == '0)
    else $error("nothing evictable reported with nonzero count");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("scan compare active outside scan");

endmodule

FILE: tb/tb_lru_k_frame_replacer.sv
// testbench of the lru-k frame replacer: directed and random requests checked beat by beat
module tb_lru_k_frame_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import lrukfr_pkg::*;

  // sizes of the block as instantiated (its default parameters)
  localparam int FRAMES = 64;
  localparam int DEPTH  = 8;
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  // register byte addresses, four bytes apart
  localparam logic [APB_AW-1:0] ADDR_HISTORY_K     = {REG_HISTORY_K, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = {REG_FRAMES_IN_USE, 2'b00};

  // cycles from an evict beat to the next request beat, plus some margin
  localparam int SETTLE_CYCLES = 72;

  typedef struct packed {
    status_t              status;
    logic [FRAME_W-1:0]   victim;
    logic [COUNT_W-1:0]   evictable_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  lrukfr_req_if req ();
  lrukfr_rsp_if rsp ();

  lru_k_frame_replacer DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral copy of the replacer state
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]  seen_times [FRAMES][DEPTH];
  logic [2:0]         ring_head  [FRAMES];
  logic [3:0]         kept_count [FRAMES];   // zero means the frame is untracked
  logic               pinned     [FRAMES];
  logic [COUNT_W-1:0] evictable_frames;
  logic [TIME_W-1:0]  now_stamp;
  logic [HK_W-1:0]    cfg_history_k;
  logic [COUNT_W-1:0] cfg_frames;

  reply_t pending_replies [$];   // replies owed by the block, oldest first
  int     failures = 0;

  // idling controls shared by the sender, the receiver and the tests
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int hold_request = 0;          // long receiver hold-off, picked up by the sink

  task automatic model_reset();
    for (int i = 0; i < FRAMES; i++) begin
      for (int j = 0; j < DEPTH; j++) seen_times[i][j] = '0;
      ring_head[i]  = '0;
      kept_count[i] = '0;
      pinned[i]     = 1'b0;
    end
    evictable_frames = '0;
    now_stamp        = '0;
    cfg_history_k    = 4'd2;
    cfg_frames       = 7'd64;
  endtask

  // k in force: zero acts as one, above the ring depth acts as the depth
  function automatic int window_k();
    if (cfg_history_k < 1) return 1;
    if (cfg_history_k > DEPTH) return DEPTH;
    return cfg_history_k;
  endfunction

  function automatic int frame_bound();
    return (cfg_frames > FRAMES) ? FRAMES : cfg_frames;
  endfunction

  // applies one request to the copied state and returns the reply it owes
  function automatic reply_t apply_request(kind_t kind, logic [FRAME_W-1:0] f, logic ev);
    reply_t            rep;
    int                k, used, best, best_used;
    bit                found, take, a_few, b_few;
    logic [TIME_W-1:0] t, best_t;
    rep.status = ST_OK;
    rep.victim = '0;
    k = window_k();
    found = 1'b0;
    best = 0;
    best_used = 0;
    best_t = '0;
    if (kind == KIND_EVICT) begin
      // scan every frame, whatever frames_in_use says now
      for (int i = 0; i < FRAMES; i++) begin
        if (kept_count[i] != 0 && !pinned[i]) begin
          used = (kept_count[i] < k) ? kept_count[i] : k;
          // oldest time inside the window of the k most recent
          t = seen_times[i][(int'(ring_head[i]) + DEPTH - used) % DEPTH];
          if (!found) begin
            take = 1'b1;
          end else begin
            a_few = used < k;
            b_few = best_used < k;
            // short histories first, then strictly older front time
            if (a_few != b_few) take = a_few;
            else take = t < best_t;
          end
          if (take) begin
            found = 1'b1;
            best = i;
            best_used = used;
            best_t = t;
          end
        end
      end
      if (found) begin
        ring_head[best]  = '0;
        kept_count[best] = '0;
        pinned[best]     = 1'b0;
        if (evictable_frames != 0) evictable_frames--;
        rep.victim = FRAME_W'(best);
      end else begin
        rep.status = ST_EMPTY;
      end
    end else if (f >= frame_bound()) begin
      // rejected frame: nothing moves, time included
      rep.status = ST_RANGE;
    end else if (kind == KIND_ACCESS) begin
      if (now_stamp < TIME_TOP) now_stamp++;
      seen_times[f][ring_head[f]] = now_stamp;
      ring_head[f] = ring_head[f] + 3'd1;
      if (kept_count[f] == 0) begin
        // first access tracks the frame as evictable
        pinned[f] = 1'b0;
        evictable_frames++;
      end
      if (kept_count[f] < DEPTH) kept_count[f]++;
    end else if (kind == KIND_MARK) begin
      if (kept_count[f] != 0) begin
        if (ev && pinned[f]) begin
          pinned[f] = 1'b0;
          evictable_frames++;
        end else if (!ev && !pinned[f]) begin
          pinned[f] = 1'b1;
          if (evictable_frames != 0) evictable_frames--;
        end
      end
    end else begin
      if (kept_count[f] != 0) begin
        if (pinned[f]) begin
          rep.status = ST_PINNED;
        end else begin
          ring_head[f]  = '0;
          kept_count[f] = '0;
          pinned[f]     = 1'b0;
          if (evictable_frames != 0) evictable_frames--;
        end
      end
    end
    rep.evictable_count = evictable_frames;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // offers one request beat and records the reply it owes once taken;
  // valid stays high when the next beat follows with no gap
  task automatic send_request(kind_t kind, logic [FRAME_W-1:0] f, logic ev);
    int gap;
    gap = src_idle ? idle_len() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.kind      <= kind;
    req.frame     <= f;
    req.evictable <= ev;
    do @(posedge clk); while (!req.ready);
    pending_replies.push_back(apply_request(kind, f, ev));
  endtask

  // stop offering and wait for every owed reply
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // setup phase, access phase until pready, then back to idle
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_HISTORY_K) cfg_history_k = data[HK_W-1:0];
    else if (addr == ADDR_FRAMES_IN_USE) cfg_frames = data[COUNT_W-1:0];
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_config(int k, int frames);
    drain();
    write_reg(ADDR_HISTORY_K, APB_DW'(k));
    write_reg(ADDR_FRAMES_IN_USE, APB_DW'(frames));
  endtask

  // receiver: random stalls, or a long hold-off when a test asks for one
  initial begin : resp_sink
    int low_left;
    low_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        low_left = hold_request;
        hold_request = 0;
      end else if (low_left == 0 && sink_idle && $urandom_range(0, 2) == 0) begin
        low_left = idle_len();
      end
      if (low_left > 0) begin
        rsp.ready <= 1'b0;
        low_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // every reply beat against the oldest owed reply
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply beat with no request waiting: status %0d victim %0d count %0d",
               rsp.status, rsp.victim, rsp.evictable_count);
        failures++;
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.victim !== want.victim) begin
          $error("victim mismatch: expected %0d, got %0d", want.victim, rsp.victim);
          failures++;
        end
        if (rsp.evictable_count !== want.evictable_count) begin
          $error("evictable_count mismatch: expected %0d, got %0d",
                 want.evictable_count, rsp.evictable_count);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every request kind and the corner cases at reset settings (k = 2, 64 frames)
  task automatic test_directed_requests();
    send_request(KIND_EVICT, 6'd0, 1'b0);    // nothing tracked yet
    send_request(KIND_MARK, 6'd5, 1'b1);     // mark on untracked frame
    send_request(KIND_REMOVE, 6'd5, 1'b0);   // remove of untracked frame
    send_request(KIND_ACCESS, 6'd0, 1'b0);   // new frames come in evictable
    send_request(KIND_ACCESS, 6'd63, 1'b1);
    send_request(KIND_ACCESS, 6'd63, 1'b0);
    send_request(KIND_ACCESS, 6'd0, 1'b0);
    send_request(KIND_MARK, 6'd63, 1'b0);    // pin
    send_request(KIND_MARK, 6'd63, 1'b0);    // already pinned
    send_request(KIND_REMOVE, 6'd63, 1'b0);  // refused, pinned
    send_request(KIND_MARK, 6'd63, 1'b1);    // release
    send_request(KIND_MARK, 6'd63, 1'b1);    // already evictable
    send_request(KIND_ACCESS, 6'd7, 1'b1);   // single access, short history
    send_request(KIND_EVICT, 6'd42, 1'b1);   // short history wins
    send_request(KIND_EVICT, 6'd0, 1'b0);    // oldest front time wins
    send_request(KIND_REMOVE, 6'd63, 1'b0);
    send_request(KIND_EVICT, 6'd0, 1'b0);    // empty again
  endtask

  // frames_in_use and history_k at their extremes
  task automatic test_register_limits();
    send_request(KIND_ACCESS, 6'd40, 1'b0);
    set_config(1, 1);
    send_request(KIND_ACCESS, 6'd40, 1'b0);  // out of range now
    send_request(KIND_MARK, 6'd40, 1'b0);
    send_request(KIND_REMOVE, 6'd40, 1'b0);
    send_request(KIND_ACCESS, 6'd0, 1'b1);
    send_request(KIND_EVICT, 6'd0, 1'b0);    // frame 40 is still a candidate
    set_config(15, 0);                       // k above depth, no frame in range
    send_request(KIND_ACCESS, 6'd0, 1'b0);
    send_request(KIND_EVICT, 6'd0, 1'b0);
    set_config(8, 127);
    send_request(KIND_ACCESS, 6'd63, 1'b0);
    send_request(KIND_EVICT, 6'd0, 1'b0);
  endtask

  // receiver holds off long while the sender keeps offering back to back
  task automatic test_backpressure();
    int r;
    set_config(2, 64);
    src_idle = 1'b0;
    hold_request = 400;
    repeat (30) begin
      r = $urandom_range(0, 3);
      send_request(kind_t'(r), 6'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
    drain();
    src_idle = 1'b1;
  endtask

  // phases of random traffic over a small pool of frames, under several settings
  task automatic test_random_traffic();
    int                 k_list  [7] = '{2, 1, 8, 15, 0, 5, 3};
    int                 fr_list [7] = '{64, 64, 127, 64, 16, 1, 40};
    int                 bound, pool, r;
    kind_t              kind;
    logic [FRAME_W-1:0] f;
    for (int p = 0; p < 7; p++) begin
      set_config(k_list[p], fr_list[p]);
      // some phases run with one side or the other never idling
      src_idle  = (p % 3) != 1;
      sink_idle = (p % 3) != 2;
      bound = frame_bound();
      pool = (p == 2) ? bound : $urandom_range(1, (bound < 12) ? bound : 12);
      repeat (86) begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = KIND_ACCESS;
        else if (r < 65) kind = KIND_MARK;
        else if (r < 78) kind = KIND_REMOVE;
        else kind = KIND_EVICT;
        // mostly the pool, sometimes any frame index
        if ($urandom_range(0, 9) == 0) f = FRAME_W'($urandom_range(0, FRAMES - 1));
        else f = FRAME_W'($urandom_range(0, pool - 1));
        send_request(kind, f, $urandom_range(0, 3) != 0);
      end
    end
    drain();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    req.valid     <= 1'b0;
    req.kind      <= KIND_ACCESS;
    req.frame     <= '0;
    req.evictable <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst           <= 1'b1;
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_requests();
    test_register_limits();
    test_backpressure();
    test_random_traffic();

    drain();
    // let a last scan run out before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
design/lrukfr_pkg.sv
design/lrukfr_if.sv
design/lru_k_frame_replacer.sv
tb/tb_lru_k_frame_replacer.sv
